FILE: sv/imu_frame_parser_yaw_filter_defines.svh
// ----------------------------------------------------------------------------
// imu frame parser assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef IMU_FRAME_PARSER_YAW_FILTER_DEFINES_SVH
`define IMU_FRAME_PARSER_YAW_FILTER_DEFINES_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("imu frame parser: assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imu frame parser: assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/imu_pkg.sv
// ----------------------------------------------------------------------------
// imu frame parser package
// shared types, frame codes and stream widths
// ----------------------------------------------------------------------------
`default_nettype none

package imu_pkg;

    localparam logic [7:0] SYNC_BYTE  = 8'h55;
    localparam logic [7:0] TYPE_ACCEL = 8'h51;
    localparam logic [7:0] TYPE_GYRO  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;
    localparam logic [7:0] TYPE_MAG   = 8'h54;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 3;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_YAW_JUMP    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_YAW_REJECTS = 2'd1;

    typedef enum logic [2:0] {
        KIND_ACCEL = 3'd0,
        KIND_GYRO  = 3'd1,
        KIND_ANGLE = 3'd2,
        KIND_MAG   = 3'd3,
        KIND_OTHER = 3'd4
    } t_kind;

    typedef struct packed {
        logic               hit;
        t_kind              kind;
        logic [7:0]         type_byte;
        logic signed [15:0] value_x;
        logic signed [15:0] value_y;
        logic signed [15:0] value_z;
    } t_frame;

    typedef struct packed {
        logic [15:0] held_yaw;
        logic        accepted;
        logic        forced;
        logic        rejected;
    } t_yaw_res;

endpackage

`default_nettype wire

FILE: sv/imu_parser.sv
// ----------------------------------------------------------------------------
// imu frame window and checksum
// sliding byte window with a running 8-bit sum, frame check and field decode
// ----------------------------------------------------------------------------
`default_nettype none

module imu_parser #(
    parameter int FRAME_LEN = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_byte,
    output imu_pkg::t_frame    o_frame
);
    import imu_pkg::*;

    localparam int DEPTH = FRAME_LEN - 1;
    localparam int CNT_W = $clog2(FRAME_LEN);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_LEN - 1);

    logic [7:0]       r_win [DEPTH];
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_sum, n_sum;
    logic             w_full, w_pass, w_fail;
    logic [7:0]       w_pos [8];

    assign w_full = (r_count == CNT_FULL);
    assign w_pass = i_valid && w_full && (r_win[0] == SYNC_BYTE) && (r_sum == i_byte);
    assign w_fail = i_valid && w_full && !w_pass;

    for (genvar k = 0; k < DEPTH; k++) begin : g_win
        logic [7:0] w_src;
        logic [7:0] n_byte;
        if (k < DEPTH - 1) begin : g_mid
            assign w_src = r_win[k+1];
        end else begin : g_top
            assign w_src = i_byte;
        end
        always_comb begin
            n_byte = r_win[k];
            if (w_fail) begin
                n_byte = w_src;
            end else if (i_valid && (r_count == CNT_W'(k))) begin
                n_byte = i_byte;
            end
        end
        always_ff @(posedge i_clk) begin
            r_win[k] <= n_byte;
        end
    end

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        if (w_pass) begin
            n_count = '0;
            n_sum   = '0;
        end else if (w_fail) begin
            n_sum   = r_sum - r_win[0] + i_byte;
        end else if (i_valid) begin
            n_count = r_count + 1'b1;
            n_sum   = r_sum + i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    // frame positions, all read from the held window; the byte arriving now is the checksum
    for (genvar p = 0; p < 8; p++) begin : g_pos
        if (p < DEPTH) begin : g_held
            assign w_pos[p] = r_win[p];
        end else if (p == DEPTH) begin : g_new
            assign w_pos[p] = i_byte;
        end else begin : g_none
            assign w_pos[p] = 8'h00;
        end
    end

    always_comb begin
        o_frame           = '0;
        o_frame.hit       = w_pass;
        o_frame.type_byte = w_pos[1];
        o_frame.value_x   = {w_pos[3], w_pos[2]};
        o_frame.value_y   = {w_pos[5], w_pos[4]};
        o_frame.value_z   = {w_pos[7], w_pos[6]};
        unique case (w_pos[1])
            TYPE_ACCEL: o_frame.kind = KIND_ACCEL;
            TYPE_GYRO:  o_frame.kind = KIND_GYRO;
            TYPE_ANGLE: o_frame.kind = KIND_ANGLE;
            TYPE_MAG:   o_frame.kind = KIND_MAG;
            default:    o_frame.kind = KIND_OTHER;
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/imu_yaw_filter.sv
// ----------------------------------------------------------------------------
// imu yaw spike filter
// wrapped yaw jump check with a consecutive rejection counter
// ----------------------------------------------------------------------------
`default_nettype none

module imu_yaw_filter (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire imu_pkg::t_frame i_frame,
    input  wire logic [15:0]   i_max_jump,
    input  wire logic [7:0]    i_max_rejects,
    output imu_pkg::t_yaw_res  o_res
);
    import imu_pkg::*;

    logic        r_valid, n_valid;
    logic [15:0] r_yaw, n_yaw;
    logic [7:0]  r_rej, n_rej;
    logic        w_angle, w_within, w_force;
    logic [15:0] w_new, w_diff;
    logic [16:0] w_mag;
    logic [8:0]  w_inc;

    assign w_angle  = i_frame.hit && (i_frame.kind == KIND_ANGLE);
    assign w_new    = i_frame.value_z;
    assign w_diff   = w_new - r_yaw;
    assign w_mag    = w_diff[15] ? (17'h10000 - {1'b0, w_diff}) : {1'b0, w_diff};
    assign w_within = !r_valid || (w_mag <= {1'b0, i_max_jump});
    assign w_inc    = {1'b0, r_rej} + 9'd1;
    assign w_force  = (w_inc >= {1'b0, i_max_rejects});

    always_comb begin
        n_valid = r_valid;
        n_yaw   = r_yaw;
        n_rej   = r_rej;
        o_res   = '0;
        if (w_angle) begin
            n_valid = 1'b1;
            if (w_within) begin
                n_yaw          = w_new;
                n_rej          = '0;
                o_res.accepted = 1'b1;
            end else if (w_force) begin
                n_yaw          = w_new;
                n_rej          = '0;
                o_res.forced   = 1'b1;
            end else begin
                n_rej          = w_inc[7:0];
                o_res.rejected = 1'b1;
            end
        end
        o_res.held_yaw = n_yaw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_yaw   <= '0;
            r_rej   <= '0;
        end else begin
            r_valid <= n_valid;
            r_yaw   <= n_yaw;
            r_rej   <= n_rej;
        end
    end

endmodule

`default_nettype wire

FILE: sv/imu_frame_parser_yaw_filter.sv
// ----------------------------------------------------------------------------
// imu frame parser with yaw filter
// eleven-byte sensor frame parser on a byte stream, spike filter on yaw
// ----------------------------------------------------------------------------
// One serial byte enters per item and the block takes one item every clock
// cycle unless the output stalls. Each byte is held in an input register,
// then checked and decoded in a single pass against a sliding window and a
// running checksum register, so a frame result is registered in the output
// register once its last byte leaves the input register; bytes that complete
// no valid frame give no result. While a result waits on the output side the
// input register takes one more byte, then stalls until the result is taken.
`default_nettype none

`include "imu_frame_parser_yaw_filter_defines.svh"

module imu_frame_parser_yaw_filter #(
    parameter int FRAME_LEN = 11
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [imu_pkg::IN_TDATA_W-1:0] s_axis_tdata,   // rx_byte
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // type_byte, value_x, value_y, value_z, held_yaw,
    // yaw_accepted, yaw_forced, yaw_rejected
    output logic [imu_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic [imu_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,   // frame_kind
    input  wire logic                           i_cfg_we,
    input  wire logic [imu_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [imu_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import imu_pkg::*;

    logic                   r_in_valid, n_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TUSER_W-1:0] r_out_kind;
    logic [15:0]            r_max_jump;
    logic [7:0]             r_max_rejects;
    logic                   w_fire, w_s_take;
    t_frame                 w_frame;
    t_yaw_res               w_yaw;

    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;
    assign w_s_take      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_s_take) begin
            n_in_valid = 1'b1;
        end else if (w_fire) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid = w_frame.hit;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_take) begin
            r_in_byte <= s_axis_tdata;
        end
        if (w_fire && w_frame.hit) begin
            r_out_kind <= w_frame.kind;
            r_out_data <= {5'b0, w_yaw.rejected, w_yaw.forced, w_yaw.accepted,
                           w_yaw.held_yaw, w_frame.value_z, w_frame.value_y,
                           w_frame.value_x, w_frame.type_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_jump    <= 16'd1820;
            r_max_rejects <= 8'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MAX_YAW_JUMP:    r_max_jump    <= i_cfg_data;
                CFG_MAX_YAW_REJECTS: r_max_rejects <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    imu_parser #(
        .FRAME_LEN (FRAME_LEN)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fire),
        .i_byte  (r_in_byte),
        .o_frame (w_frame)
    );

    imu_yaw_filter u_yaw (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame       (w_frame),
        .i_max_jump    (r_max_jump),
        .i_max_rejects (r_max_rejects),
        .o_res         (w_yaw)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;

    `ASSERT_ALWAYS(a_flags_onehot, i_clk, i_rst_n,
        r_out_valid |-> $onehot0(r_out_data[74:72]))
    `ASSERT_ALWAYS(a_flags_angle_only, i_clk, i_rst_n,
        (r_out_valid && (r_out_kind != KIND_ANGLE)) |-> (r_out_data[74:72] == 3'b000))
    `ASSERT_ALWAYS(a_forced_takes_yaw, i_clk, i_rst_n,
        (r_out_valid && r_out_data[73]) |-> (r_out_data[71:56] == r_out_data[55:40]))
    `ASSERT_NEXT(a_in_reg_held, i_clk, i_rst_n,
        r_in_valid && !w_fire, r_in_valid && $stable(r_in_byte))

endmodule

`default_nettype wire

FILE: sim/tb_imu_frame_parser_yaw_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu frame parser with yaw filter - testbench
// feeds serial bytes as whole frames, broken frames and line noise, predicts
// every decoded frame and the yaw spike filter decision, and checks each
// result field by field, with random idling on both stream sides in most tests
// ----------------------------------------------------------------------------
module tb_imu_frame_parser_yaw_filter;
    import imu_pkg::*;

    localparam int  FRAME_LEN      = 11;
    localparam int  CLK_HALF       = 6;
    localparam int  LONG_HOLD      = 150;
    localparam int  SETTLE_CYCLES  = 8;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct {
        t_kind       kind;
        logic [7:0]  type_byte;
        logic [15:0] value_x;
        logic [15:0] value_y;
        logic [15:0] value_z;
        logic [15:0] held_yaw;
        logic        accepted;
        logic        forced;
        logic        rejected;
    } t_frame_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // type_byte, value_x, value_y, value_z, held_yaw,
                                            // yaw_accepted, yaw_forced, yaw_rejected
    logic [OUT_TUSER_W-1:0] m_axis_tuser;   // frame_kind
    logic                   i_cfg_we;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // parser and filter state as the block should hold it
    logic [7:0]  win_bytes [0:FRAME_LEN-1];
    int unsigned win_count;
    logic        yaw_held_valid;
    logic [15:0] yaw_held;
    logic [7:0]  yaw_reject_run;
    logic [15:0] cfg_max_jump;
    logic [7:0]  cfg_max_rejects;

    t_frame_result pending_frames [$];

    int unsigned mismatches;
    int unsigned bytes_sent;
    int unsigned frames_checked;
    int unsigned yaw_accept_cnt;
    int unsigned yaw_forced_cnt;
    int unsigned yaw_reject_cnt;
    int unsigned settings_used;
    bit          src_idle_en;
    bit          sink_idle_en;
    bit          long_hold_req;

    imu_frame_parser_yaw_filter #(
        .FRAME_LEN(FRAME_LEN)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin
        #(4_000_000);
        $display("timeout with %0d frames still awaited", pending_frames.size());
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at frame %0d, %s: got %0h, expected %0h",
                 frames_checked, field, got, want);
        mismatches++;
    endtask

    function automatic void drop_oldest_byte();
        for (int unsigned i = 0; i + 1 < win_count; i++) begin
            win_bytes[i] = win_bytes[i + 1];
        end
        win_count--;
    endfunction

    // window update and frame decode for one accepted byte
    function automatic void parse_rx_byte(input logic [7:0] rx);
        logic [7:0]    sum;
        logic [15:0]   diff;
        logic [16:0]   mag;
        logic [8:0]    run;
        t_frame_result res;
        sum = 8'd0;
        win_bytes[win_count] = rx;
        win_count++;
        if (win_count < FRAME_LEN) begin
            return;
        end
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            sum += win_bytes[i];
        end
        if (win_bytes[0] != SYNC_BYTE || sum != win_bytes[FRAME_LEN-1]) begin
            drop_oldest_byte();
            return;
        end
        res.type_byte = win_bytes[1];
        case (win_bytes[1])
            TYPE_ACCEL: res.kind = KIND_ACCEL;
            TYPE_GYRO:  res.kind = KIND_GYRO;
            TYPE_ANGLE: res.kind = KIND_ANGLE;
            TYPE_MAG:   res.kind = KIND_MAG;
            default:    res.kind = KIND_OTHER;
        endcase
        res.value_x  = {win_bytes[3], win_bytes[2]};
        res.value_y  = {win_bytes[5], win_bytes[4]};
        res.value_z  = {win_bytes[7], win_bytes[6]};
        res.accepted = 1'b0;
        res.forced   = 1'b0;
        res.rejected = 1'b0;
        if (res.kind == KIND_ANGLE) begin
            diff = res.value_z - yaw_held;
            mag  = diff[15] ? (17'h10000 - {1'b0, diff}) : {1'b0, diff};
            if (!yaw_held_valid || mag <= {1'b0, cfg_max_jump}) begin
                yaw_held       = res.value_z;
                yaw_reject_run = 8'd0;
                res.accepted   = 1'b1;
            end else begin
                run = {1'b0, yaw_reject_run} + 9'd1;
                if (run >= {1'b0, cfg_max_rejects}) begin
                    yaw_held       = res.value_z;
                    yaw_reject_run = 8'd0;
                    res.forced     = 1'b1;
                end else begin
                    yaw_reject_run = run[7:0];
                    res.rejected   = 1'b1;
                end
            end
            yaw_held_valid = 1'b1;
        end
        res.held_yaw = yaw_held;
        pending_frames.push_back(res);
        win_count = 0;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_frame_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_frames.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
            end else begin
                want = pending_frames.pop_front();
                if (m_axis_tuser != want.kind)
                    report_mismatch("frame_kind", 32'(m_axis_tuser), 32'(want.kind));
                if (m_axis_tdata[7:0] != want.type_byte)
                    report_mismatch("type_byte", 32'(m_axis_tdata[7:0]),
                                    32'(want.type_byte));
                if (m_axis_tdata[23:8] != want.value_x)
                    report_mismatch("value_x", 32'(m_axis_tdata[23:8]),
                                    32'(want.value_x));
                if (m_axis_tdata[39:24] != want.value_y)
                    report_mismatch("value_y", 32'(m_axis_tdata[39:24]),
                                    32'(want.value_y));
                if (m_axis_tdata[55:40] != want.value_z)
                    report_mismatch("value_z", 32'(m_axis_tdata[55:40]),
                                    32'(want.value_z));
                if (m_axis_tdata[71:56] != want.held_yaw)
                    report_mismatch("held_yaw", 32'(m_axis_tdata[71:56]),
                                    32'(want.held_yaw));
                if (m_axis_tdata[72] != want.accepted)
                    report_mismatch("yaw_accepted", 32'(m_axis_tdata[72]),
                                    32'(want.accepted));
                if (m_axis_tdata[73] != want.forced)
                    report_mismatch("yaw_forced", 32'(m_axis_tdata[73]),
                                    32'(want.forced));
                if (m_axis_tdata[74] != want.rejected)
                    report_mismatch("yaw_rejected", 32'(m_axis_tdata[74]),
                                    32'(want.rejected));
                if (m_axis_tdata[79:75] != 5'd0)
                    report_mismatch("tdata padding", 32'(m_axis_tdata[79:75]), 32'd0);
                yaw_accept_cnt += 32'(want.accepted);
                yaw_forced_cnt += 32'(want.forced);
                yaw_reject_cnt += 32'(want.rejected);
            end
            frames_checked++;
        end
    end

    // result side ready, with random and long hold-offs
    initial begin
        int unsigned gap;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 7);
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // starts and ends on a falling edge; valid stays high afterwards
    task automatic send_byte(input logic [7:0] rx);
        int unsigned gap;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        parse_rx_byte(rx);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [7:0] type_b, input logic [15:0] vx,
                              input logic [15:0] vy, input logic [15:0] vz,
                              input bit bad_sum, input int unsigned n_bytes);
        logic [7:0] fb [0:FRAME_LEN-1];
        fb[0] = SYNC_BYTE;
        fb[1] = type_b;
        {fb[3], fb[2]} = vx;
        {fb[5], fb[4]} = vy;
        {fb[7], fb[6]} = vz;
        fb[8] = 8'($urandom_range(0, 255));
        fb[9] = 8'($urandom_range(0, 255));
        fb[FRAME_LEN-1] = 8'd0;
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            fb[FRAME_LEN-1] += fb[i];
        end
        if (bad_sum) begin
            fb[FRAME_LEN-1] ^= 8'($urandom_range(1, 255));
        end
        for (int unsigned i = 0; i < n_bytes; i++) begin
            send_byte(fb[i]);
        end
    endtask

    // let everything in flight come out, with the stream input quiet
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
        case (addr)
            CFG_MAX_YAW_JUMP:    cfg_max_jump    = data;
            CFG_MAX_YAW_REJECTS: cfg_max_rejects = data[7:0];
            default: ;
        endcase
    endtask

    task automatic set_filter(input logic [15:0] jump, input logic [7:0] rejects);
        drain_results();
        write_reg(CFG_MAX_YAW_JUMP, jump);
        // upper byte is junk, the register keeps only the low byte
        write_reg(CFG_MAX_YAW_REJECTS, {8'($urandom_range(0, 255)), rejects});
        settings_used++;
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'hffff;
            3:       return 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // yaw near the filter edges around the held value
    function automatic logic [15:0] pick_yaw();
        case ($urandom_range(0, 8))
            0:       return yaw_held + cfg_max_jump;
            1:       return yaw_held - cfg_max_jump;
            2:       return yaw_held + cfg_max_jump + 16'd1;
            3:       return yaw_held - cfg_max_jump - 16'd1;
            4:       return yaw_held + 16'h8000;
            5:       return yaw_held + 16'($urandom_range(0, cfg_max_jump));
            6:       return yaw_held - 16'($urandom_range(0, cfg_max_jump));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_random_frames(input int unsigned n_frames);
        int unsigned sel;
        int unsigned k;
        logic [7:0]  type_b;
        logic [15:0] vz;
        for (int unsigned f = 0; f < n_frames; f++) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0:       type_b = TYPE_ACCEL;
                1:       type_b = TYPE_GYRO;
                2:       type_b = TYPE_MAG;
                3:       type_b = 8'($urandom_range(0, 255));
                default: type_b = TYPE_ANGLE;
            endcase
            vz  = (type_b == TYPE_ANGLE) ? pick_yaw() : pick_value();
            sel = $urandom_range(0, 99);
            if (sel < 80) begin
                send_frame(type_b, pick_value(), pick_value(), vz, 1'b0, FRAME_LEN);
            end else if (sel < 88) begin
                send_frame(type_b, pick_value(), pick_value(), vz, 1'b1, FRAME_LEN);
            end else if (sel < 94) begin
                k = $urandom_range(1, 6);
                repeat (k) send_byte(8'($urandom_range(0, 255)));
            end else begin
                k = $urandom_range(1, FRAME_LEN - 1);
                send_frame(type_b, pick_value(), pick_value(), vz, 1'b0, k);
            end
        end
    endtask

    task automatic test_directed_frames();
        send_frame(TYPE_ACCEL, 16'h8000, 16'h7fff, 16'hffff, 1'b0, FRAME_LEN);
        // stray sync byte ahead of a frame, parser has to slip by one
        send_byte(SYNC_BYTE);
        send_frame(TYPE_ANGLE, 16'h0000, 16'h0000, 16'h0000, 1'b0, FRAME_LEN);
        send_frame(TYPE_ANGLE, 16'hffff, 16'h0001, 16'h8000, 1'b0, FRAME_LEN);
    endtask

    task automatic test_default_filter();
        send_random_frames(15);
    endtask

    task automatic test_tight_filter();
        set_filter(16'd0, 8'd1);
        send_random_frames(15);
    endtask

    task automatic test_loose_filter();
        set_filter(16'd32768, 8'd255);
        drain_results();
        write_reg(CFG_SPARE_2, 16'($urandom_range(0, 65535)));
        write_reg(CFG_SPARE_3, 16'($urandom_range(0, 65535)));
        send_random_frames(15);
    endtask

    task automatic test_zero_reject_limit();
        set_filter(16'd100, 8'd0);
        send_random_frames(10);
    endtask

    task automatic test_output_backpressure();
        set_filter(16'($urandom_range(0, 4000)), 8'($urandom_range(1, 4)));
        long_hold_req = 1'b1;
        send_random_frames(15);
    endtask

    task automatic test_mixed_settings();
        repeat (3) begin
            set_filter(16'($urandom_range(0, 32768)), 8'($urandom_range(1, 8)));
            send_random_frames(10);
        end
    endtask

    task automatic test_full_rate();
        set_filter(16'($urandom_range(0, 2000)), 8'($urandom_range(1, 3)));
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        send_random_frames(15);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        m_axis_tready   = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = '0;
        i_cfg_data      = '0;
        win_count       = 0;
        yaw_held_valid  = 1'b0;
        yaw_held        = 16'd0;
        yaw_reject_run  = 8'd0;
        cfg_max_jump    = 16'd1820;
        cfg_max_rejects = 8'd5;
        for (int i = 0; i < FRAME_LEN; i++) win_bytes[i] = 8'd0;
        mismatches      = 0;
        bytes_sent      = 0;
        frames_checked  = 0;
        yaw_accept_cnt  = 0;
        yaw_forced_cnt  = 0;
        yaw_reject_cnt  = 0;
        settings_used   = 1;
        src_idle_en     = 1'b1;
        sink_idle_en    = 1'b1;
        long_hold_req   = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_frames();
        test_default_filter();
        test_tight_filter();
        test_loose_filter();
        test_zero_reject_limit();
        test_output_backpressure();
        test_mixed_settings();
        test_full_rate();
        drain_results();

        while (pending_frames.size() != 0) begin
            report_mismatch("result never came", pending_frames.size(), 32'd0);
            void'(pending_frames.pop_front());
        end
        $display("covered %0d bytes over %0d filter settings, %0d frames decoded",
                 bytes_sent, settings_used, frames_checked);
        $display("yaw decisions: %0d accepted, %0d forced, %0d rejected",
                 yaw_accept_cnt, yaw_forced_cnt, yaw_reject_cnt);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
